FILE: rtl/pod_pkg.sv
// Shared types, constants and the Bayer threshold table for the palette ordered dither.
package pod_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int IDX_W         = 9;
  localparam int CH_W          = 8;
  localparam int COLOUR_W      = 4 * CH_W;
  localparam int DIFF_W        = CH_W + 2;
  localparam int PROD_W        = DIFF_W + 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 9;
  localparam int IN_DATA_W     = 56;
  localparam int OUT_DATA_W    = 16;

  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(PALETTE_DEPTH);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  localparam logic [1:0] MOVE_KEEP     = 2'd0;
  localparam logic [1:0] MOVE_DARKER   = 2'd1;
  localparam logic [1:0] MOVE_BRIGHTER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLORS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSP_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THR   = 2'd2;

  localparam logic [IDX_W-1:0] NUM_COLORS_RST = 9'd256;

  typedef struct packed {
    logic [IDX_W-1:0] num_colors;
    logic             transp_en;
    logic [CH_W-1:0]  alpha_thr;
  } cfg_t;

  // stage 1: registered pixel fields and early flags
  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [COLOUR_W-1:0] pix_colour;
    logic [CH_W-1:0]     red;
    logic [3:0]          factor;
    logic                kept;
    logic                has_next;
    logic                has_prev;
  } s1_t;

  // registered palette reads
  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic [CH_W-1:0]     b_cur;
    logic [CH_W-1:0]     b_next;
    logic [CH_W-1:0]     b_prev;
  } rd_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic [3:0]               factor;
    logic                     kept;
    logic                     gt;
    logic signed [DIFF_W-1:0] opa;
    logic signed [DIFF_W-1:0] opb;
  } s2_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     kept;
    logic                     gt;
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] pb;
  } s3_t;

  function automatic logic [3:0] bayer_factor(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] f;
    case ({row, col})
      4'h0: f = 4'd0;
      4'h1: f = 4'd8;
      4'h2: f = 4'd2;
      4'h3: f = 4'd10;
      4'h4: f = 4'd12;
      4'h5: f = 4'd4;
      4'h6: f = 4'd14;
      4'h7: f = 4'd6;
      4'h8: f = 4'd3;
      4'h9: f = 4'd11;
      4'hA: f = 4'd1;
      4'hB: f = 4'd9;
      4'hC: f = 4'd15;
      4'hD: f = 4'd7;
      4'hE: f = 4'd13;
      4'hF: f = 4'd5;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/pod_front.sv
// Input stage: palette memories, registered reads and early pixel flags.
module pod_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          action,
  input  logic [pod_pkg::IDX_W-1:0]     idx,
  input  logic [pod_pkg::CH_W-1:0]      red,
  input  logic [pod_pkg::CH_W-1:0]      green,
  input  logic [pod_pkg::CH_W-1:0]      blue,
  input  logic [pod_pkg::CH_W-1:0]      alpha,
  input  logic [pod_pkg::CH_W-1:0]      entry_gray,
  input  logic [1:0]                    col_phase,
  input  logic [1:0]                    row_phase,
  input  pod_pkg::cfg_t                 cfg,
  output logic                          v1,
  output pod_pkg::s1_t                  s1,
  output pod_pkg::rd_t                  rd
);
  import pod_pkg::*;

  logic [COLOUR_W-1:0] colour_mem [PALETTE_DEPTH];
  logic [CH_W-1:0]     bri_a_mem  [PALETTE_DEPTH];
  logic [CH_W-1:0]     bri_b_mem  [PALETTE_DEPTH];

  logic                v1_r, v1_nxt;
  s1_t                 s1_r, s1_nxt;
  rd_t                 rd_r;
  logic [IDX_W-1:0]    used;
  logic [ADDR_W-1:0]   addr, addr_next, addr_prev;
  logic [COLOUR_W-1:0] colour;
  logic                wr_en;

  assign used      = (cfg.num_colors > DEPTH_IDX) ? DEPTH_IDX : cfg.num_colors;
  assign addr      = idx[ADDR_W-1:0];
  assign addr_next = addr + ADDR_W'(1);
  assign addr_prev = addr - ADDR_W'(1);
  assign colour    = {red, green, blue, alpha};
  assign wr_en     = en && in_valid && (action == ACT_LOAD) && (idx < DEPTH_IDX);

  always_comb begin
    v1_nxt            = in_valid && (action == ACT_PIXEL);
    s1_nxt.idx        = idx;
    s1_nxt.pix_colour = colour;
    s1_nxt.red        = red;
    s1_nxt.factor     = bayer_factor(row_phase, col_phase);
    s1_nxt.kept       = (cfg.transp_en && (alpha <= cfg.alpha_thr)) || (idx >= used);
    s1_nxt.has_next   = ({1'b0, idx} + (IDX_W+1)'(1)) < {1'b0, used};
    s1_nxt.has_prev   = (idx != '0);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      colour_mem[addr] <= colour;
      bri_a_mem[addr]  <= entry_gray;
      bri_b_mem[addr]  <= entry_gray;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r.colour <= colour_mem[addr];
      rd_r.b_cur  <= bri_a_mem[addr];
      rd_r.b_next <= bri_a_mem[addr_next];
      rd_r.b_prev <= bri_b_mem[addr_prev];
      s1_r        <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v1_nxt;
    end
  end

  assign v1 = v1_r;
  assign s1 = s1_r;
  assign rd = rd_r;

endmodule

FILE: rtl/pod_arith.sv
// Middle stages: colour match and brightness differences, then threshold products.
module pod_arith (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en2,
  input  logic         en3,
  input  logic         v1,
  input  pod_pkg::s1_t s1,
  input  pod_pkg::rd_t rd,
  output logic         v2,
  output logic         v3,
  output pod_pkg::s3_t s3
);
  import pod_pkg::*;

  logic v2_r, v3_r;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;

  logic signed [DIFF_W-1:0] go, gp, gn, gq;
  logic                     match;

  assign go    = $signed({2'b00, s1.red});
  assign gp    = $signed({2'b00, rd.b_cur});
  assign gn    = $signed({2'b00, rd.b_next});
  assign gq    = $signed({2'b00, rd.b_prev});
  assign match = (s1.pix_colour == rd.colour);

  always_comb begin
    s2_nxt.idx    = s1.idx;
    s2_nxt.factor = s1.factor;
    s2_nxt.gt     = gp > go;
    if (gp > go) begin
      s2_nxt.opa  = go - gn;
      s2_nxt.opb  = gp - gn;
      s2_nxt.kept = s1.kept || match || !s1.has_next;
    end else begin
      s2_nxt.opa  = go - gp;
      s2_nxt.opb  = gq - gp;
      s2_nxt.kept = s1.kept || match || !s1.has_prev;
    end
  end

  always_comb begin
    s3_nxt.idx  = s2_r.idx;
    s3_nxt.kept = s2_r.kept;
    s3_nxt.gt   = s2_r.gt;
    s3_nxt.pa   = $signed({s2_r.opa[DIFF_W-1], s2_r.opa, 4'b0000});
    s3_nxt.pb   = PROD_W'(s2_r.opb) * PROD_W'($signed({1'b0, s2_r.factor}));
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_r <= s2_nxt;
    end
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en2) begin
        v2_r <= v1;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  assign v2 = v2_r;
  assign v3 = v3_r;
  assign s3 = s3_r;

endmodule

FILE: rtl/pod_decide.sv
// Output stage: threshold compare and the result register.
module pod_decide (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      v3,
  input  pod_pkg::s3_t              s3,
  output logic                      out_valid,
  output logic [pod_pkg::IDX_W-1:0] out_index,
  output logic [1:0]                dither_move
);
  import pod_pkg::*;

  logic             valid_r;
  logic [IDX_W-1:0] index_r, index_nxt;
  logic [1:0]       move_r, move_nxt;

  always_comb begin
    index_nxt = s3.idx;
    move_nxt  = MOVE_KEEP;
    if (!s3.kept) begin
      if (s3.gt) begin
        if (s3.pa < s3.pb) begin
          index_nxt = s3.idx + IDX_W'(1);
          move_nxt  = MOVE_DARKER;
        end
      end else begin
        if (s3.pa >= s3.pb) begin
          index_nxt = s3.idx - IDX_W'(1);
          move_nxt  = MOVE_BRIGHTER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      index_r <= index_nxt;
      move_r  <= move_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= v3;
    end
  end

  assign out_valid   = valid_r;
  assign out_index   = index_r;
  assign dither_move = move_r;

endmodule

FILE: rtl/palette_ordered_dither.sv
// Top level of the 4x4 ordered dither for palette indices.
//
// Usage: load the palette first with words that have in_tuser low (one entry per
// word, address in the index field; addresses at or beyond the table are dropped).
// Entries must be sorted bright to dark. Pixel words (in_tuser high) each give one
// result word on the out_ channel; load words give none.
// Configuration writes go over the cfg_ channel, which is always ready, and the
// user must make them while the pipeline is empty; the block does not enforce it.
// One word is taken per cycle unless out_tready back-pressure fills every stage.
// A pixel word passes a four-stage pipeline (palette read, difference, product,
// compare) and reaches out_tvalid through the v1, v2, v3 and output valid flops.
// A load followed directly by a pixel sees the new entry.
// Reset clears every stage valid and sets num_colors to 256, transparency off and
// alpha threshold 0. The palette holds no defined data until loaded.
// A stall on out_tready holds the output word; the stages behind it fill up and
// in_tready falls only once every stage holds a word.
module palette_ordered_dither (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // palette_index[8:0], red[16:9], green[24:17], blue[32:25], alpha[40:33],
  // entry_gray[48:41], col_phase[50:49], row_phase[52:51], zero[55:53]
  input  logic [pod_pkg::IN_DATA_W-1:0]     in_tdata,
  // action[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_index[8:0], dither_move[10:9], zero[15:11]
  output logic [pod_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pod_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pod_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pod_pkg::*;

  cfg_t             cfg_r;
  logic             en1, en2, en3, en_o;
  logic             v1, v2, v3;
  s1_t              s1;
  rd_t              rd;
  s3_t              s3;
  logic [IDX_W-1:0] res_index;
  logic [1:0]       res_move;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_colors <= NUM_COLORS_RST;
      cfg_r.transp_en  <= 1'b0;
      cfg_r.alpha_thr  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_COLORS: cfg_r.num_colors <= cfg_data[IDX_W-1:0];
        REG_TRANSP_EN:  cfg_r.transp_en  <= cfg_data[0];
        REG_ALPHA_THR:  cfg_r.alpha_thr  <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  assign en_o      = !out_tvalid || out_tready;
  assign en3       = !v3 || en_o;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign in_tready = en1;

  pod_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en1),
    .in_valid   (in_tvalid),
    .action     (in_tuser),
    .idx        (in_tdata[8:0]),
    .red        (in_tdata[16:9]),
    .green      (in_tdata[24:17]),
    .blue       (in_tdata[32:25]),
    .alpha      (in_tdata[40:33]),
    .entry_gray (in_tdata[48:41]),
    .col_phase  (in_tdata[50:49]),
    .row_phase  (in_tdata[52:51]),
    .cfg        (cfg_r),
    .v1         (v1),
    .s1         (s1),
    .rd         (rd)
  );

  pod_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .en2   (en2),
    .en3   (en3),
    .v1    (v1),
    .s1    (s1),
    .rd    (rd),
    .v2    (v2),
    .v3    (v3),
    .s3    (s3)
  );

  pod_decide u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en_o),
    .v3          (v3),
    .s3          (s3),
    .out_valid   (out_tvalid),
    .out_index   (res_index),
    .dither_move (res_move)
  );

  assign out_tdata = {5'b00000, res_move, res_index};

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready with output register empty");

  a_load_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ACT_LOAD)) |=> !v1)
    else $error("load word entered the pixel pipeline");

  a_kept_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v3 && s3.kept && en_o) |=> (out_tdata[10:9] == MOVE_KEEP) && out_tvalid)
    else $error("kept pixel produced a move");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for palette_ordered_dither: palette loads, pixel words, register settings.
module tb_top;
  import pod_pkg::*;

  typedef struct {
    logic       action;
    logic [8:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] gray;
    logic [1:0] col;
    logic [1:0] row;
  } dither_word_t;

  typedef struct {
    logic [8:0] index;
    logic [1:0] move;
  } dither_result_t;

  localparam int BAYER [4][4] = '{'{0, 8, 2, 10}, '{12, 4, 14, 6},
                                  '{3, 11, 1, 9}, '{15, 7, 13, 5}};
  localparam int DRAIN_CYCLES = 8;

  class dither_scoreboard;
    logic [31:0]    colour [PALETTE_DEPTH];
    logic [7:0]     bright [PALETTE_DEPTH];
    logic [8:0]     num_colors;
    logic           transp_en;
    logic [7:0]     alpha_thr;
    dither_result_t expected_q [$];
    int             errors;
    int             checked;

    function new();
      num_colors = NUM_COLORS_RST;
      transp_en  = 1'b0;
      alpha_thr  = 8'd0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NUM_COLORS: num_colors = data;
        REG_TRANSP_EN:  transp_en  = data[0];
        REG_ALPHA_THR:  alpha_thr  = data[7:0];
        default: ;
      endcase
    endfunction

    // palette update or dither prediction for one accepted word
    function void note_input(dither_word_t w);
      int             used;
      int             i;
      int             gp;
      int             go;
      int             gn;
      int             factor;
      bit             keep;
      dither_result_t r;
      i = w.index;
      if (w.action == ACT_LOAD) begin
        if (i < PALETTE_DEPTH) begin
          colour[i] = {w.red, w.green, w.blue, w.alpha};
          bright[i] = w.gray;
        end
        return;
      end
      used    = (num_colors > PALETTE_DEPTH) ? PALETTE_DEPTH : num_colors;
      r.index = w.index;
      r.move  = MOVE_KEEP;
      keep = (transp_en && w.alpha <= alpha_thr) || (i >= used);
      if (!keep) keep = ({w.red, w.green, w.blue, w.alpha} == colour[i]);
      if (!keep) begin
        gp     = bright[i];
        go     = w.red;
        factor = BAYER[w.row][w.col];
        if (gp > go) begin
          if (i + 1 < used) begin
            gn = bright[i + 1];
            if ((go - gn) * 16 < (gp - gn) * factor) begin
              r.index = 9'(i + 1);
              r.move  = MOVE_DARKER;
            end
          end
        end else if (i > 0) begin
          gn = bright[i - 1];
          if ((go - gp) * 16 >= (gn - gp) * factor) begin
            r.index = 9'(i - 1);
            r.move  = MOVE_BRIGHTER;
          end
        end
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      dither_result_t e;
      if (expected_q.size() == 0) begin
        $error("result word %h arrived with nothing expected", word);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (word[8:0] !== e.index) begin
        $error("out_index: expected %0d, actual %0d", e.index, word[8:0]);
        errors++;
      end
      if (word[10:9] !== e.move) begin
        $error("dither_move: expected %0d, actual %0d", e.move, word[10:9]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  dither_scoreboard sb = new();

  logic [7:0]  pal_bright [PALETTE_DEPTH];
  logic [31:0] pal_colour [PALETTE_DEPTH];
  int          cur_used      = PALETTE_DEPTH;
  int          send_idle_pct = 9;
  int          recv_idle_pct = 71;
  int          n_loads       = 0;
  int          n_cfg         = 0;

  palette_ordered_dither dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_word(dither_word_t w);
    in_tvalid <= 1'b1;
    in_tuser  <= w.action;
    in_tdata  <= {3'b000, w.row, w.col, w.gray, w.alpha, w.blue, w.green, w.red, w.index};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_input(w);
    if (w.action == ACT_LOAD) n_loads++;
  endtask

  task automatic maybe_idle();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_entry(int idx, logic [31:0] colour, logic [7:0] gray);
    dither_word_t w;
    w.action = ACT_LOAD;
    w.index  = 9'(idx);
    {w.red, w.green, w.blue, w.alpha} = colour;
    w.gray   = gray;
    w.col    = 2'($urandom);
    w.row    = 2'($urandom);
    if (idx < PALETTE_DEPTH) begin
      pal_colour[idx] = colour;
      pal_bright[idx] = gray;
    end
    send_word(w);
  endtask

  task automatic send_pixel(int idx, logic [31:0] colour, int col, int row);
    dither_word_t w;
    w.action = ACT_PIXEL;
    w.index  = 9'(idx);
    {w.red, w.green, w.blue, w.alpha} = colour;
    w.gray   = 8'($urandom);
    w.col    = 2'(col);
    w.row    = 2'(row);
    send_word(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, CFG_DATA_W'(data));
    n_cfg++;
  endtask

  task automatic set_config(int nc, int te, int thr);
    write_reg(REG_NUM_COLORS, nc);
    write_reg(REG_TRANSP_EN, te);
    write_reg(REG_ALPHA_THR, thr);
    cfg_valid <= 1'b0;
    cur_used = (nc > PALETTE_DEPTH) ? PALETTE_DEPTH : nc;
  endtask

  function automatic logic [7:0] darker_bound(int idx);
    return (idx + 1 < PALETTE_DEPTH) ? pal_bright[idx + 1] : 8'd0;
  endfunction

  function automatic logic [7:0] brighter_bound(int idx);
    return (idx > 0) ? pal_bright[idx - 1] : 8'd255;
  endfunction

  task automatic random_item();
    int          kind;
    int          idx;
    int          pick;
    logic [7:0]  red;
    logic [31:0] colour;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // rewrite an entry, keeping the table sorted
      idx = $urandom_range(0, PALETTE_DEPTH - 1);
      load_entry(idx, $urandom, 8'($urandom_range(darker_bound(idx), brighter_bound(idx))));
    end else if (kind < 10) begin
      load_entry(PALETTE_DEPTH, $urandom, 8'($urandom));
    end else if (kind < 20) begin
      send_pixel($urandom_range(0, PALETTE_DEPTH), $urandom, $urandom_range(0, 3),
                 $urandom_range(0, 3));
    end else begin
      pick = $urandom_range(0, 9);
      if (pick == 0) idx = 0;
      else if (pick == 1) idx = cur_used - 1;
      else idx = $urandom_range(0, cur_used - 1);
      red    = 8'($urandom_range(darker_bound(idx), brighter_bound(idx)));
      colour = {red, 24'($urandom)};
      if ($urandom_range(0, 9) == 0) colour = pal_colour[idx];
      send_pixel(idx, colour, $urandom_range(0, 3), $urandom_range(0, 3));
    end
  endtask

  initial begin
    int         bq [$];
    int         i;
    int         seg;
    logic [7:0] mid;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sorted palette, brightest first, both extremes present
    for (i = 0; i < PALETTE_DEPTH; i++) bq.insert(bq.size(), int'($urandom_range(0, 255)));
    bq.rsort();
    bq[0]                 = 255;
    bq[PALETTE_DEPTH - 1] = 0;
    for (i = 0; i < PALETTE_DEPTH; i++) begin
      maybe_idle();
      load_entry(i, $urandom, 8'(bq[i]));
    end
    load_entry(PALETTE_DEPTH, 32'hFFFF_FFFF, 8'hFF);

    // directed: table ends, out-of-range index, exact match, every Bayer phase
    send_pixel(0, 32'hFF00_0080, 0, 0);
    send_pixel(0, 32'h0000_0080, 1, 1);
    send_pixel(PALETTE_DEPTH - 1, 32'hFF12_3456, 2, 2);
    send_pixel(PALETTE_DEPTH - 1, 32'h0012_3456, 3, 0);
    send_pixel(PALETTE_DEPTH, 32'hFFFF_FFFF, 3, 3);
    send_pixel(10, pal_colour[10], 1, 2);
    send_pixel(128, 32'h0000_0000, 0, 0);
    mid = 8'((int'(darker_bound(100)) + int'(brighter_bound(100))) / 2);
    for (i = 0; i < 16; i++) send_pixel(100, {mid, 24'h5A_A5_C3}, i % 4, i / 4);

    // single colour in use, transparency at both threshold extremes
    wait_drained();
    set_config(1, 1, 255);
    send_pixel(0, 32'h0000_00FF, 0, 3);
    wait_drained();
    set_config(1, 1, 0);
    send_pixel(0, 32'h8000_0000, 1, 0);
    send_pixel(0, 32'h0000_0001, 2, 1);
    send_pixel(1, 32'h7F7F_7F7F, 3, 2);

    for (seg = 0; seg < 6; seg++) begin
      wait_drained();
      case (seg / 2)
        0: begin send_idle_pct = 9;  recv_idle_pct = 71; end
        1: begin send_idle_pct = 71; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (seg)
        0: set_config(256, 0, 0);
        1: set_config(2, 1, 0);
        2: set_config($urandom_range(3, 255), 1, $urandom_range(0, 255));
        3: set_config(256, 1, 128);
        4: set_config(128, 0, 255);
        default: set_config($urandom_range(2, 256), 1, 40);
      endcase
      repeat (61) begin
        maybe_idle();
        if ($urandom_range(0, 59) == 0) wait_drained();
        random_item();
      end
    end

    wait_drained();
    $display("Covered %0d pixel results, %0d palette loads and %0d register writes,",
             sb.checked, n_loads, n_cfg);
    $display("across several register settings and three back-pressure regimes.");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
